// ===== sv/lzssd_pkg.sv =====
// lzssd_pkg: shared types and constants of the lzss stream decompressor
// no dependencies; imported by lzssd_ctrl, lzssd_dp and the top level
package lzssd_pkg;

  // history window geometry
  localparam int unsigned WIN_AW   = 12;
  localparam logic [WIN_AW-1:0] WP_RESET = 12'd4078;
  localparam logic [7:0]  SPACE_BYTE = 8'h20;

  // copy length is the low nibble plus this bias
  localparam logic [4:0]  LEN_BIAS = 5'd3;
  localparam int unsigned LEN_W    = 5;

  // flag register marker
  localparam logic [8:0]  FLAG_MARK = 9'h100;

  // what an accepted byte asks the datapath to do
  typedef enum logic [1:0] {
    K_NONE = 2'd0,
    K_LIT  = 2'd1,
    K_COPY = 2'd2
  } kind_t;

  // controller to datapath commands
  typedef struct packed {
    logic accept;
    logic emit_lit;
    logic rd_issue;
    logic emit_copy;
    logic finish;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    kind_t kind;
    logic  copy_end;
    logic  out_free;
  } dp_stat_t;

endpackage

// ===== sv/lzssd_ctrl.sv =====
// lzssd_ctrl: sequencing state machine of the lzss stream decompressor
// depends on lzssd_pkg for the command and status structs
module lzssd_ctrl
  import lzssd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LIT  = 4'b0010,
    S_READ = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          case (stat.kind)
            K_LIT:   state_nxt = S_LIT;
            K_COPY:  state_nxt = S_READ;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_LIT: begin
        if (stat.out_free) begin
          cmd.emit_lit = 1'b1;
          cmd.finish   = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_READ: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit_copy = 1'b1;
          if (stat.copy_end) begin
            cmd.finish = 1'b1;
            state_nxt  = S_IDLE;
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== sv/lzssd_dp.sv =====
// lzssd_dp: token decode, history window, copy engine and output register
// depends on lzssd_pkg; driven by lzssd_ctrl commands
module lzssd_dp
  import lzssd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  input  logic [7:0]  in_comp_byte,
  input  logic        in_stream_end,
  input  logic        cfg_valid,
  input  logic [31:0] cfg_output_limit,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_run_last,
  output logic        out_limit_hit
);

  // history window, reset state tracked by the fill count
  logic [7:0] win_mem [2**WIN_AW];

  logic [31:0]       limit_r, limit_nxt;
  logic [31:0]       cnt_r, cnt_nxt;
  logic              done_r, done_nxt;
  logic [WIN_AW-1:0] wp_r, wp_nxt;
  logic [8:0]        flag_r, flag_nxt;
  logic              phase_r, phase_nxt;
  logic [7:0]        pend_r, pend_nxt;
  logic              end_r, end_nxt;
  logic [7:0]        lit_r, lit_nxt;
  logic [WIN_AW-1:0] pos_r, pos_nxt;
  logic [LEN_W-1:0]  rem_r, rem_nxt;
  logic [7:0]        rd_data_r;
  logic              rd_ok_r, rd_ok_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_byte_r, out_byte_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_hit_r, out_hit_nxt;

  logic              stop;
  logic [31:0]       cnt_inc;
  logic              hit;
  logic              emit;
  logic              clr;
  logic [WIN_AW-1:0] fill_dist;
  logic [7:0]        emit_byte;
  kind_t             kind;

  assign cnt_inc   = cnt_r + 32'd1;
  assign hit       = (cnt_inc == limit_r);
  assign stop      = done_r || (cnt_r >= limit_r);
  assign emit      = cmd.emit_lit || cmd.emit_copy;
  assign fill_dist = pos_r - WP_RESET;
  assign emit_byte = cmd.emit_lit ? lit_r : (rd_ok_r ? rd_data_r : SPACE_BYTE);

  // token classification of the byte on the input
  always_comb begin
    if (stop) begin
      kind = K_NONE;
    end else if (phase_r) begin
      kind = K_COPY;
    end else if (flag_r <= 9'd1) begin
      kind = K_NONE;
    end else if (flag_r[0]) begin
      kind = K_LIT;
    end else begin
      kind = K_NONE;
    end
  end

  assign clr = (cmd.accept && (kind == K_NONE) && in_stream_end) || (cmd.finish && end_r);

  assign stat.kind     = kind;
  assign stat.copy_end = (rem_r == LEN_W'(1)) || hit;
  assign stat.out_free = !out_valid_r || out_ready;

  // state update
  always_comb begin
    limit_nxt     = limit_r;
    cnt_nxt       = cnt_r;
    done_nxt      = done_r;
    wp_nxt        = wp_r;
    flag_nxt      = flag_r;
    phase_nxt     = phase_r;
    pend_nxt      = pend_r;
    end_nxt       = end_r;
    lit_nxt       = lit_r;
    pos_nxt       = pos_r;
    rem_nxt       = rem_r;
    rd_ok_nxt     = rd_ok_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_hit_nxt   = out_hit_r;

    // configuration write
    if (cfg_valid) begin
      limit_nxt = cfg_output_limit;
    end

    // decode an accepted byte
    if (cmd.accept) begin
      end_nxt = in_stream_end;
      if (stop) begin
        done_nxt = 1'b1;
      end else if (phase_r) begin
        pos_nxt   = {in_comp_byte[7:4], pend_r};
        rem_nxt   = {1'b0, in_comp_byte[3:0]} + LEN_BIAS;
        phase_nxt = 1'b0;
        flag_nxt  = flag_r >> 1;
      end else if (flag_r <= 9'd1) begin
        flag_nxt = FLAG_MARK | {1'b0, in_comp_byte};
      end else if (flag_r[0]) begin
        lit_nxt  = in_comp_byte;
        flag_nxt = flag_r >> 1;
      end else begin
        pend_nxt  = in_comp_byte;
        phase_nxt = 1'b1;
      end
    end

    // window read, entries outside the fill count read as space
    if (cmd.rd_issue) begin
      rd_ok_nxt = (|cnt_r[31:WIN_AW]) || (fill_dist < cnt_r[WIN_AW-1:0]);
      pos_nxt   = pos_r + WIN_AW'(1);
    end

    // output register
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = emit_byte;
      out_hit_nxt   = hit;
      out_last_nxt  = cmd.emit_lit || (rem_r == LEN_W'(1)) || hit;
      cnt_nxt       = cnt_inc;
      wp_nxt        = wp_r + WIN_AW'(1);
      if (hit) begin
        done_nxt = 1'b1;
      end
      if (cmd.emit_copy) begin
        rem_nxt = rem_r - LEN_W'(1);
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    // end of stream returns to the start state
    if (clr) begin
      cnt_nxt   = '0;
      done_nxt  = 1'b0;
      wp_nxt    = WP_RESET;
      flag_nxt  = '0;
      phase_nxt = 1'b0;
      pend_nxt  = '0;
      end_nxt   = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= '0;
      cnt_r       <= '0;
      done_r      <= 1'b0;
      wp_r        <= WP_RESET;
      flag_r      <= '0;
      phase_r     <= 1'b0;
      pend_r      <= '0;
      end_r       <= 1'b0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      limit_r     <= limit_nxt;
      cnt_r       <= cnt_nxt;
      done_r      <= done_nxt;
      wp_r        <= wp_nxt;
      flag_r      <= flag_nxt;
      phase_r     <= phase_nxt;
      pend_r      <= pend_nxt;
      end_r       <= end_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    lit_r      <= lit_nxt;
    pos_r      <= pos_nxt;
    rd_ok_r    <= rd_ok_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    out_hit_r  <= out_hit_nxt;
  end

  // window write and registered read
  always_ff @(posedge clk) begin
    if (emit) begin
      win_mem[wp_r] <= emit_byte;
    end
    if (cmd.rd_issue) begin
      rd_data_r <= win_mem[pos_r];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_run_last  = out_last_r;
  assign out_limit_hit = out_hit_r;

  // a byte is only loaded into a free output register
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (!out_valid_r || out_ready))
    else $error("byte emitted into a full output register");

  // a copy never runs past its length
  a_copy_len: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_copy |-> (rem_r != '0))
    else $error("copy emitted with no bytes remaining");

  // end of stream restores the write position and the count
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr |=> ((wp_r == WP_RESET) && (cnt_r == '0) && !phase_r))
    else $error("stream end did not restore the start state");

  // no byte goes out once the limit was reached
  a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> !done_r)
    else $error("byte emitted after the output limit");

endmodule

// ===== sv/lzss_stream_decompressor_top.sv =====
// lzss_stream_decompressor_top: a flag byte or the first byte of a reference is taken in the
// idle state alone, a literal is held in a register and then moved to the output register in
// the literal state, and the second byte of a reference of length L runs one window read
// and one output/write step per copied byte; an emit waits on a full, stalled output
// reset: synchronous active low; a fill count makes unwritten window entries read as spaces
// depends on lzssd_pkg, lzssd_ctrl and lzssd_dp
module lzss_stream_decompressor_top
  import lzssd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_comp_byte,
  input  logic        in_stream_end,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_output_limit,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_run_last,
  output logic        out_limit_hit
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // configuration must only be written while idle; the block itself does not enforce this
  assign cfg_ready = 1'b1;

  // sequencer
  lzssd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath
  lzssd_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_comp_byte     (in_comp_byte),
    .in_stream_end    (in_stream_end),
    .cfg_valid        (cfg_valid),
    .cfg_output_limit (cfg_output_limit),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_run_last     (out_run_last),
    .out_limit_hit    (out_limit_hit)
  );

endmodule
